### design/abbd_pkg.sv
// Package for the adaptive beam break detector: widths, reset values, codes
// and the structures passed between the sequencer, divider and channel store.
// No dependencies.
`default_nettype none

package abbd_pkg;

    localparam int CHANNELS    = 6;
    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 8;

    localparam int FUNC_W   = 2;
    localparam int CH_W     = 3;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int N_W      = 9;
    localparam int SHIFT_W  = 4;
    localparam int DIV_W    = 5;

    localparam int VAL_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int TH_W    = VAL_W + 1;
    localparam int DIFF_W  = TH_W + 1;
    localparam int DELTA_W = SAMPLE_BITS + 1;

    localparam int DIV_CYCLES = DIFF_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int IN_USED_W    = CH_W + SAMPLE_BITS + N_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W   = 1 + CH_W + DELTA_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = DIV_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_SHIFT     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASELINE_SHIFT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD_SHIFT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIVISOR         = 2'd3;

    localparam logic [SHIFT_W-1:0] VALUE_SHIFT_RESET     = 4'd2;
    localparam logic [SHIFT_W-1:0] BASELINE_SHIFT_RESET  = 4'd6;
    localparam logic [SHIFT_W-1:0] THRESHOLD_SHIFT_RESET = 4'd4;
    localparam logic [DIV_W-1:0]   DIVISOR_RESET         = 5'd2;

    localparam logic [VAL_W-1:0]       VAL_RESET = VAL_W'(800 * (1 << FRAC_BITS));
    localparam logic signed [TH_W-1:0] TH_RESET  = TH_W'(100 * (1 << FRAC_BITS));

    typedef enum logic [FUNC_W-1:0] {
        FUNC_DETECT = 2'd0,
        FUNC_LIT    = 2'd1,
        FUNC_DARK   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMA,
        ST_DELTA,
        ST_CMP,
        ST_LIT,
        ST_DARK,
        ST_DIV_DELTA,
        ST_DIV_TH,
        ST_DIV_SM,
        ST_DIV_BL,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [SHIFT_W-1:0] value_shift;
        logic [SHIFT_W-1:0] baseline_shift;
        logic [SHIFT_W-1:0] threshold_shift;
        logic [DIV_W-1:0]   divisor;
    } t_cfg;

    typedef struct packed {
        t_func                  func;
        logic [CH_W-1:0]        ch;
        logic [SAMPLE_BITS-1:0] sample;
        logic [N_W-1:0]         sample_number;
    } t_item;

    typedef struct packed {
        logic                      blocked;
        logic [CH_W-1:0]           ch;
        logic signed [DELTA_W-1:0] delta;
    } t_result;

    typedef struct packed {
        logic [VAL_W-1:0]       sm;
        logic [VAL_W-1:0]       bl;
        logic signed [TH_W-1:0] th;
    } t_chan_state;

    typedef struct packed {
        logic            we;
        logic [CH_W-1:0] addr;
        t_chan_state     data;
    } t_store_wr;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] num;
        logic [N_W-1:0]           den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DIFF_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

### design/abbd_divider.sv
// Shared signed divider, truncating toward zero, two quotient bits a cycle.
// Depends on abbd_pkg.
`default_nettype none

module abbd_divider (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  abbd_pkg::t_div_req i_req,
    output abbd_pkg::t_div_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [abbd_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [abbd_pkg::DIFF_W-1:0]      r_quo;
    logic [abbd_pkg::N_W:0]           r_rem;
    logic [abbd_pkg::N_W-1:0]         r_den;
    logic                             r_neg;

    logic [abbd_pkg::DIFF_W-1:0]      n_quo;
    logic [abbd_pkg::N_W:0]           n_rem;
    logic [abbd_pkg::N_W:0]           rem_a;
    logic [abbd_pkg::N_W:0]           rem_a2;
    logic [abbd_pkg::N_W:0]           rem_b;
    logic                             bit_a;
    logic                             bit_b;
    logic [abbd_pkg::DIFF_W-1:0]      num_mag;

    always_comb begin
        rem_a  = {r_rem[abbd_pkg::N_W-1:0], r_quo[abbd_pkg::DIFF_W-1]};
        bit_a  = (rem_a >= {1'b0, r_den});
        rem_a2 = bit_a ? (rem_a - {1'b0, r_den}) : rem_a;
        rem_b  = {rem_a2[abbd_pkg::N_W-1:0], r_quo[abbd_pkg::DIFF_W-2]};
        bit_b  = (rem_b >= {1'b0, r_den});
        n_rem  = bit_b ? (rem_b - {1'b0, r_den}) : rem_b;
        n_quo  = {r_quo[abbd_pkg::DIFF_W-3:0], bit_a, bit_b};
        num_mag = i_req.num[abbd_pkg::DIFF_W-1] ? abbd_pkg::DIFF_W'(-i_req.num)
                                                : abbd_pkg::DIFF_W'(i_req.num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == abbd_pkg::DIV_CNT_W'(abbd_pkg::DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= num_mag;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.num[abbd_pkg::DIFF_W-1];
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

### design/abbd_chan_store.sv
// Per-channel state store: smoothed value, baseline and threshold.
// Depends on abbd_pkg.
`default_nettype none

module abbd_chan_store (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  abbd_pkg::t_store_wr       i_wr,
    input  wire [abbd_pkg::CH_W-1:0]  i_raddr,
    output abbd_pkg::t_chan_state     o_rdata
);

    abbd_pkg::t_chan_state r_mem [abbd_pkg::CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < abbd_pkg::CHANNELS; i++) begin
                r_mem[i] <= '{abbd_pkg::VAL_RESET, abbd_pkg::VAL_RESET, abbd_pkg::TH_RESET};
            end
        end else if (i_wr.we) begin
            r_mem[i_wr.addr[abbd_pkg::CH_IDX_W-1:0]] <= i_wr.data;
        end
    end

    assign o_rdata = r_mem[i_raddr[abbd_pkg::CH_IDX_W-1:0]];

endmodule

`default_nettype wire

### design/abbd_ctrl.sv
// Sequencer and datapath registers of the detector; drives the shared
// divider and the channel store. Depends on abbd_pkg.
`default_nettype none

module abbd_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  abbd_pkg::t_cfg          i_cfg,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  abbd_pkg::t_item         i_item,
    output logic                    o_res_valid,
    input  wire                     i_res_ready,
    output abbd_pkg::t_result       o_res,
    output abbd_pkg::t_div_req      o_div_req,
    input  abbd_pkg::t_div_rsp      i_div_rsp,
    output abbd_pkg::t_store_wr     o_store_wr,
    output logic [abbd_pkg::CH_W-1:0] o_store_raddr,
    input  abbd_pkg::t_chan_state   i_store_rdata
);

    localparam int VW = abbd_pkg::VAL_W;
    localparam int TW = abbd_pkg::TH_W;
    localparam int DW = abbd_pkg::DIFF_W;
    localparam int QW = abbd_pkg::DELTA_W;
    localparam int FB = abbd_pkg::FRAC_BITS;

    abbd_pkg::t_state r_state, n_state;
    abbd_pkg::t_func  r_func, n_func;
    logic [abbd_pkg::CH_W-1:0] r_ch, n_ch;
    logic [VW-1:0]             r_samp_q, n_samp_q;
    logic [abbd_pkg::N_W-1:0]  r_n, n_n;
    logic [VW-1:0]             r_sm, n_sm;
    logic [VW-1:0]             r_bl, n_bl;
    logic signed [TW-1:0]      r_th, n_th;
    logic signed [QW-1:0]      r_d, n_d;
    logic                      r_blocked, n_blocked;

    logic [abbd_pkg::N_W-1:0]  divisor_eff;
    logic signed [TW-1:0]      q_target;
    logic signed [QW-1:0]      dark_d;

    function automatic logic [VW-1:0] ema_val(input logic [VW-1:0] old_v,
                                              input logic [VW-1:0] tgt,
                                              input logic [abbd_pkg::SHIFT_W-1:0] sh);
        logic signed [DW-1:0] diff;
        logic signed [DW-1:0] sum;
        diff = $signed(DW'(tgt)) - $signed(DW'(old_v));
        sum  = $signed(DW'(old_v)) + (diff >>> sh);
        return sum[VW-1:0];
    endfunction

    function automatic logic signed [TW-1:0] ema_th(input logic signed [TW-1:0] old_v,
                                                    input logic signed [TW-1:0] tgt,
                                                    input logic [abbd_pkg::SHIFT_W-1:0] sh);
        logic signed [DW-1:0] diff;
        logic signed [DW-1:0] sum;
        diff = DW'(tgt) - DW'(old_v);
        sum  = DW'(old_v) + (diff >>> sh);
        return sum[TW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] trunc_int(input logic signed [TW-1:0] x);
        logic [TW-1:0] mag;
        logic [TW-1:0] sh;
        mag = x[TW-1] ? TW'(-x) : TW'(x);
        sh  = mag >> FB;
        return x[TW-1] ? -$signed(sh[QW-1:0]) : $signed(sh[QW-1:0]);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abbd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_ch      <= n_ch;
        r_samp_q  <= n_samp_q;
        r_n       <= n_n;
        r_sm      <= n_sm;
        r_bl      <= n_bl;
        r_th      <= n_th;
        r_d       <= n_d;
        r_blocked <= n_blocked;
    end

    always_comb begin
        divisor_eff = (i_cfg.divisor == '0) ? abbd_pkg::N_W'(1)
                                            : abbd_pkg::N_W'(i_cfg.divisor);
        q_target = $signed({i_div_rsp.quot[QW-1:0], {FB{1'b0}}});
        dark_d   = trunc_int($signed(TW'(r_bl)) - $signed(TW'(r_samp_q)));

        n_state   = r_state;
        n_func    = r_func;
        n_ch      = r_ch;
        n_samp_q  = r_samp_q;
        n_n       = r_n;
        n_sm      = r_sm;
        n_bl      = r_bl;
        n_th      = r_th;
        n_d       = r_d;
        n_blocked = r_blocked;

        o_in_ready      = 1'b0;
        o_res_valid     = 1'b0;
        o_div_req.start = 1'b0;
        o_div_req.num   = '0;
        o_div_req.den   = r_n;
        o_store_wr.we   = 1'b0;
        o_store_wr.addr = r_ch;
        o_store_wr.data = '{r_sm, r_bl, r_th};

        case (r_state)
            abbd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_func    = i_item.func;
                    n_ch      = i_item.ch;
                    n_samp_q  = {i_item.sample, {FB{1'b0}}};
                    n_n       = (i_item.sample_number == '0) ? abbd_pkg::N_W'(1)
                                                             : i_item.sample_number;
                    n_blocked = 1'b0;
                    n_d       = '0;
                    n_state   = abbd_pkg::ST_LOAD;
                end
            end
            abbd_pkg::ST_LOAD: begin
                n_sm = i_store_rdata.sm;
                n_bl = i_store_rdata.bl;
                n_th = i_store_rdata.th;
                if ({1'b0, r_ch} >= (abbd_pkg::CH_W + 1)'(abbd_pkg::CHANNELS)) begin
                    n_state = abbd_pkg::ST_DONE;
                end else begin
                    case (r_func)
                        abbd_pkg::FUNC_DETECT: n_state = abbd_pkg::ST_EMA;
                        abbd_pkg::FUNC_LIT:    n_state = abbd_pkg::ST_LIT;
                        abbd_pkg::FUNC_DARK:   n_state = abbd_pkg::ST_DARK;
                        default:               n_state = abbd_pkg::ST_DONE;
                    endcase
                end
            end
            abbd_pkg::ST_EMA: begin
                n_sm    = ema_val(r_sm, r_samp_q, i_cfg.value_shift);
                n_state = abbd_pkg::ST_DELTA;
            end
            abbd_pkg::ST_DELTA: begin
                n_d     = trunc_int($signed(TW'(r_bl)) - $signed(TW'(r_sm)));
                n_state = abbd_pkg::ST_CMP;
            end
            abbd_pkg::ST_CMP: begin
                if ($signed({r_d, {FB{1'b0}}}) > r_th) begin
                    n_blocked       = 1'b1;
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DW'(r_d);
                    o_div_req.den   = divisor_eff;
                    n_state         = abbd_pkg::ST_DIV_DELTA;
                end else begin
                    n_bl    = ema_val(r_bl, r_sm, i_cfg.baseline_shift);
                    n_state = abbd_pkg::ST_WRITE;
                end
            end
            abbd_pkg::ST_DARK: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = DW'(dark_d);
                o_div_req.den   = divisor_eff;
                n_state         = abbd_pkg::ST_DIV_DELTA;
            end
            abbd_pkg::ST_DIV_DELTA: begin
                if (i_div_rsp.done) begin
                    if (r_func == abbd_pkg::FUNC_DETECT) begin
                        n_th    = ema_th(r_th, q_target, i_cfg.threshold_shift);
                        n_state = abbd_pkg::ST_WRITE;
                    end else begin
                        o_div_req.start = 1'b1;
                        o_div_req.num   = DW'(q_target) - DW'(r_th);
                        n_state         = abbd_pkg::ST_DIV_TH;
                    end
                end
            end
            abbd_pkg::ST_DIV_TH: begin
                if (i_div_rsp.done) begin
                    n_th    = TW'(DW'(r_th) + i_div_rsp.quot);
                    n_state = abbd_pkg::ST_WRITE;
                end
            end
            abbd_pkg::ST_LIT: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = $signed(DW'(r_samp_q)) - $signed(DW'(r_sm));
                n_state         = abbd_pkg::ST_DIV_SM;
            end
            abbd_pkg::ST_DIV_SM: begin
                if (i_div_rsp.done) begin
                    n_sm            = VW'($signed(DW'(r_sm)) + i_div_rsp.quot);
                    o_div_req.start = 1'b1;
                    o_div_req.num   = $signed(DW'(r_samp_q)) - $signed(DW'(r_bl));
                    n_state         = abbd_pkg::ST_DIV_BL;
                end
            end
            abbd_pkg::ST_DIV_BL: begin
                if (i_div_rsp.done) begin
                    n_bl    = VW'($signed(DW'(r_bl)) + i_div_rsp.quot);
                    n_state = abbd_pkg::ST_WRITE;
                end
            end
            abbd_pkg::ST_WRITE: begin
                o_store_wr.we = 1'b1;
                n_state       = abbd_pkg::ST_DONE;
            end
            abbd_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = abbd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = abbd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_store_raddr = r_ch;
    assign o_res.blocked = r_blocked;
    assign o_res.ch      = r_ch;
    assign o_res.delta   = r_d;

endmodule

`default_nettype wire

### design/adaptive_beam_break_detector_top.sv
// Top level of the adaptive beam break detector: stream ports, configuration
// registers and output register. Depends on abbd_pkg, abbd_ctrl,
// abbd_divider and abbd_chan_store.
//
// The block takes one sample beat at a time and is not ready again until its
// result has been handed to the output register. An unblocked detect needs no
// division, a blocked detect one and either calibration two; the longer runs
// are set by the shared divider, which produces two quotient bits a cycle.
// The next beat may be taken while the previous result still waits at the
// output.
`default_nettype none

module adaptive_beam_break_detector_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // channel, sample, sample_number
    input  wire [abbd_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // func
    input  wire [abbd_pkg::FUNC_W-1:0]           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // blocked, channel_out, delta_out
    output logic [abbd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  wire                                  i_cfg_we,
    input  wire [abbd_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire [abbd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    abbd_pkg::t_cfg        r_cfg;
    abbd_pkg::t_item       item;
    abbd_pkg::t_result     res;
    abbd_pkg::t_result     r_out;
    logic                  r_out_valid;
    logic                  res_valid;
    logic                  res_ready;
    abbd_pkg::t_div_req    div_req;
    abbd_pkg::t_div_rsp    div_rsp;
    abbd_pkg::t_store_wr   store_wr;
    logic [abbd_pkg::CH_W-1:0] store_raddr;
    abbd_pkg::t_chan_state store_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.value_shift     <= abbd_pkg::VALUE_SHIFT_RESET;
            r_cfg.baseline_shift  <= abbd_pkg::BASELINE_SHIFT_RESET;
            r_cfg.threshold_shift <= abbd_pkg::THRESHOLD_SHIFT_RESET;
            r_cfg.divisor         <= abbd_pkg::DIVISOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                abbd_pkg::CFG_VALUE_SHIFT: begin
                    r_cfg.value_shift <= i_cfg_wdata[abbd_pkg::SHIFT_W-1:0];
                end
                abbd_pkg::CFG_BASELINE_SHIFT: begin
                    r_cfg.baseline_shift <= i_cfg_wdata[abbd_pkg::SHIFT_W-1:0];
                end
                abbd_pkg::CFG_THRESHOLD_SHIFT: begin
                    r_cfg.threshold_shift <= i_cfg_wdata[abbd_pkg::SHIFT_W-1:0];
                end
                abbd_pkg::CFG_DIVISOR: begin
                    r_cfg.divisor <= i_cfg_wdata[abbd_pkg::DIV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        item.func          = abbd_pkg::t_func'(i_s_tuser);
        item.ch            = i_s_tdata[abbd_pkg::CH_W-1:0];
        item.sample        = i_s_tdata[abbd_pkg::CH_W +: abbd_pkg::SAMPLE_BITS];
        item.sample_number = i_s_tdata[abbd_pkg::CH_W + abbd_pkg::SAMPLE_BITS +: abbd_pkg::N_W];
    end

    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = abbd_pkg::OUT_TDATA_W'({r_out.delta, r_out.ch, r_out.blocked});

    abbd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_item        (item),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .o_store_wr    (store_wr),
        .o_store_raddr (store_raddr),
        .i_store_rdata (store_rdata)
    );

    abbd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    abbd_chan_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (store_wr),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

endmodule

`default_nettype wire

### design/abbd_checker.sv
// Port-level checks for the adaptive beam break detector, bound to the top.
// Depends on abbd_pkg.
`default_nettype none

module abbd_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_s_tvalid,
    input wire                               o_s_tready,
    input wire                               o_m_tvalid,
    input wire                               i_m_tready,
    input wire [abbd_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    localparam int DLO = 1 + abbd_pkg::CH_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("Output beat dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("Output beat changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("Input accepted again before the sample was processed.");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Output valid after reset.");

    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[DLO + abbd_pkg::DELTA_W - 1:DLO] != 11'h400))
        else $error("Delta outside the range of a baseline difference.");

endmodule

bind adaptive_beam_break_detector_top abbd_checker u_abbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);

`default_nettype wire
